/* rtl/tspd_pkg.sv */
package tspd_pkg;

   localparam int OP_W       = 2;
   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 8;
   localparam int WINDOW_W   = 16;
   localparam int EVENT_W    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd3;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 16'd2000;

   typedef enum logic [OP_W-1:0] {
      OP_BEAM   = 2'd0,
      OP_ULTRA  = 2'd1,
      OP_TICK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_A_ACTIVE  = 3'd1,
      EV_B_ACTIVE  = 3'd2,
      EV_ENTRY     = 3'd3,
      EV_EXIT      = 3'd4,
      EV_CANCELLED = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SEEN_A = 3'b010,
      PH_SEEN_B = 3'b100
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_WINDOW   = 1'b1
   } csr_index_type;

endpackage

/* rtl/tspd_req_if.sv */
interface tspd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tspd_pkg::OP_W-1:0]     operation;
   logic                          beam_blocked;
   logic [tspd_pkg::TIME_W-1:0]   time_ms;

   modport source (output valid, output operation, output beam_blocked, output time_ms,
                   input ready);
   modport sink (input valid, input operation, input beam_blocked, input time_ms,
                 output ready);
endinterface

/* rtl/tspd_rsp_if.sv */
interface tspd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tspd_pkg::EVENT_W-1:0]   event_code;

   modport source (output valid, output event_code, input ready);
   modport sink (input valid, input event_code, output ready);
endinterface

/* rtl/tspd_debounce.sv */
module tspd_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sample_en,
   input  logic                              blocked,
   input  logic [tspd_pkg::DEBOUNCE_W-1:0]   threshold,
   output logic                              trigger
);
   import tspd_pkg::*;

   logic [DEBOUNCE_W-1:0] run_ff, run_in, run_sat;
   logic                  latched_ff, latched_in;
   logic                  reached;

   always_comb begin
      run_sat = (run_ff < threshold) ? run_ff + 1'b1 : run_ff;
      reached = !(run_sat < threshold);
      trigger = sample_en && blocked && reached && !latched_ff;
      run_in = run_ff;
      latched_in = latched_ff;
      if (sample_en) begin
         if (blocked) begin
            run_in = run_sat;
            latched_in = latched_ff || reached;
         end else begin
            run_in = '0;
            latched_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         latched_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         latched_ff <= latched_in;
      end
   end

endmodule

/* rtl/two_sensor_passage_direction_unit.sv */
// Passage direction from an optical beam (sensor A, debounced) and an ultrasonic trigger
// (sensor B). Every request gives exactly one response: A then B is an entry, B then A an
// exit, a lone first trigger reports its sensor, and a timeout check cancels a pending
// sequence once more than window_ms has passed (32-bit wrapping milliseconds). A request is
// taken every cycle while the response register is free or being drained, and its response
// appears in the next cycle, from the response register that the single state update feeds.
module two_sensor_passage_direction_unit (
   input  logic                              clock,
   input  logic                              reset,
   tspd_req_if.sink                          req,
   tspd_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [tspd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tspd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tspd_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [WINDOW_W-1:0]   window_ff, window_in;
   phase_type             phase_ff, phase_in;
   logic [TIME_W-1:0]     first_ff, first_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             event_ff, event_in, ev;
   logic [TIME_W-1:0]     elapsed;
   logic                  accept, beam_trigger;
   op_type                op;

   assign op = op_type'(req.operation);
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.event_code = event_ff;

   tspd_debounce u_debounce (
      .clock     (clock),
      .reset     (reset),
      .sample_en (accept && (op == OP_BEAM)),
      .blocked   (req.beam_blocked),
      .threshold (debounce_ff),
      .trigger   (beam_trigger)
   );

   assign elapsed = req.time_ms - first_ff;

   always_comb begin
      debounce_in = debounce_ff;
      window_in = window_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: debounce_in = csr_wdata[DEBOUNCE_W-1:0];
            CSR_WINDOW:   window_in = csr_wdata[WINDOW_W-1:0];
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      ev = EV_NONE;
      unique case (op)
         OP_BEAM: begin
            if (beam_trigger) begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = PH_SEEN_A;
                  first_in = req.time_ms;
                  ev = EV_A_ACTIVE;
               end else if (phase_ff == PH_SEEN_B) begin
                  phase_in = PH_IDLE;
                  first_in = '0;
                  ev = EV_EXIT;
               end
            end
         end
         OP_ULTRA: begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_SEEN_B;
               first_in = req.time_ms;
               ev = EV_B_ACTIVE;
            end else if (phase_ff == PH_SEEN_A) begin
               phase_in = PH_IDLE;
               first_in = '0;
               ev = EV_ENTRY;
            end
         end
         OP_TICK: begin
            if (phase_ff != PH_IDLE && elapsed > {{(TIME_W-WINDOW_W){1'b0}}, window_ff}) begin
               phase_in = PH_IDLE;
               first_in = '0;
               ev = EV_CANCELLED;
            end
         end
         OP_CLEAR: begin
            phase_in = PH_IDLE;
            first_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      event_in = event_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         event_in = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         window_ff <= WINDOW_RESET;
         phase_ff <= PH_IDLE;
         first_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff <= debounce_in;
         window_ff <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            first_ff <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
   end

endmodule

/* rtl/tspd_checker.sv */
module tspd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [tspd_pkg::OP_W-1:0]         req_operation,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [tspd_pkg::EVENT_W-1:0]      rsp_event_code
);
   import tspd_pkg::*;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // every transfer in gives a response in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   // a clear never reports an event
   a_clear_none: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_CLEAR |=> rsp_event_code == EV_NONE)
      else $error("clear reported an event");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind two_sensor_passage_direction_unit tspd_checker u_tspd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_operation  (req.operation),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_event_code (rsp.event_code)
);
